@@ hw/rtl/ieel_pkg.sv @@
// Shared types and constants for the indexed insert/erase list.
`timescale 1ns / 1ps
package ieel_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    CMD_INSERT     = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_ERASE      = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_POP_FRONT  = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  position;
    logic [31:0] item_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] removed_word;
    logic [5:0]  found_index;
    logic [6:0]  entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

@@ hw/rtl/indexed_insert_erase_list.sv @@
// Result strobe: out_valid in the report state that follows the execute state, one cycle wide.
// No transaction is taken during execute; the next is taken while a result is shown.
// The execute state does the work on the cell chain (shift, compare, count update).
// Results cannot be stalled by the receiver.
// Reset: synchronous active low; clears count and controller, entries are not cleared.
`timescale 1ns / 1ps
module indexed_insert_erase_list
  import ieel_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctl_t ctl;

  ieel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  ieel_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_item  (in_item),
    .out_item (out_item)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter execute");

  a_exec_report: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute not followed by result strobe");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_EMPTY) |->
      (out_item.entry_count == '0 && out_item.removed_word == '0))
    else $error("empty status with entries or removed word");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_FULL || out_item.status == ST_NOT_FOUND)) |->
      (out_item.removed_word == '0))
    else $error("removed word on a failed insert or find");

endmodule

@@ hw/rtl/ieel_ctrl.sv @@
// Controller state machine: load, execute and report phases of a transaction.
`timescale 1ns / 1ps
module ieel_ctrl
  import ieel_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy      = (state_r == S_EXEC);
  assign out_valid = (state_r == S_REPORT);
  assign accept    = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:   state_nxt = S_REPORT;
      S_REPORT: state_nxt = accept ? S_EXEC : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ctl.load = accept;
  assign ctl.exec = (state_r == S_EXEC);

endmodule

@@ hw/rtl/ieel_dp.sv @@
// Datapath: cell chain of entries, entry count, parallel compare and result registers.
`timescale 1ns / 1ps
module ieel_dp
  import ieel_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int AW = (CW > 7) ? CW : 7;

  logic [WORD_WIDTH-1:0] cell_r   [CAPACITY];
  logic [WORD_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [CW-1:0]         count_r, count_nxt;

  logic [2:0]            cmd_r;
  logic [AW-1:0]         pos_r;
  logic [WORD_WIDTH-1:0] word_r;

  logic [2:0]            status_r, status_nxt;
  logic [WORD_WIDTH-1:0] removed_r, removed_nxt;
  logic                  find_r;
  logic [CAPACITY-1:0]   match_r, match_nxt;

  logic [AW-1:0]         at, cnt_a, cap_a;
  logic                  is_ins, is_era, do_in, do_out;
  logic [WORD_WIDTH-1:0] gone;
  logic [IW-1:0]         hit_idx;

  assign cnt_a = AW'(count_r);
  assign cap_a = AW'(CAPACITY);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_item.command;
      pos_r  <= AW'(in_item.position);
      word_r <= WORD_WIDTH'(in_item.item_word);
    end
  end

  always_comb begin
    is_ins = 1'b0;
    is_era = 1'b0;
    at     = '0;
    case (cmd_r)
      CMD_INSERT: begin
        is_ins = 1'b1;
        at     = pos_r;
      end
      CMD_PUSH_BACK: begin
        is_ins = 1'b1;
        at     = cnt_a;
      end
      CMD_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      CMD_ERASE: begin
        is_era = 1'b1;
        at     = pos_r;
      end
      CMD_POP_BACK: begin
        is_era = 1'b1;
        at     = cnt_a - AW'(1);
      end
      CMD_POP_FRONT: begin
        is_era = 1'b1;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  always_comb begin
    status_nxt = ST_OK;
    do_in      = 1'b0;
    do_out     = 1'b0;
    if (is_ins) begin
      if (at > cnt_a) begin
        status_nxt = ST_RANGE;
      end else if (cnt_a >= cap_a) begin
        status_nxt = ST_FULL;
      end else begin
        do_in = 1'b1;
      end
    end else if (is_era) begin
      if (cnt_a == '0) begin
        status_nxt = ST_EMPTY;
      end else if (at >= cnt_a) begin
        status_nxt = ST_RANGE;
      end else begin
        do_out = 1'b1;
      end
    end
  end

  always_comb begin
    gone = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (AW'(k) == at) begin
        gone = cell_r[k];
      end
    end
  end

  assign removed_nxt = do_out ? gone : '0;

  always_comb begin
    count_nxt = count_r;
    if (do_in) begin
      count_nxt = count_r + CW'(1);
    end else if (do_out) begin
      count_nxt = count_r - CW'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    always_comb begin
      cell_nxt[k] = cell_r[k];
      if (do_in) begin
        if (AW'(k) == at) begin
          cell_nxt[k] = word_r;
        end else if (AW'(k) > at) begin
          if (k > 0) begin
            cell_nxt[k] = cell_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (do_out) begin
        if ((AW'(k) >= at) && (k < CAPACITY - 1)) begin
          cell_nxt[k] = cell_r[(k < CAPACITY - 1) ? k + 1 : k];
        end
      end
    end

    assign match_nxt[k] = (CW'(k) < count_r) && (cell_r[k] == word_r);

    always_ff @(posedge clk) begin
      if (ctl.exec) begin
        cell_r[k] <= cell_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      find_r    <= (cmd_r == CMD_FIND);
      match_r   <= match_nxt;
    end
  end

  // lowest matching index wins
  always_comb begin
    hit_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match_r[k]) begin
        hit_idx = IW'(k);
      end
    end
  end

  always_comb begin
    out_item.status       = status_r;
    out_item.removed_word = 32'(removed_r);
    out_item.found_index  = '0;
    out_item.entry_count  = 7'(count_r);
    if (find_r) begin
      out_item.status      = (|match_r) ? ST_OK : ST_NOT_FOUND;
      out_item.found_index = 6'(hit_idx);
    end
  end

endmodule

@@ test/testbench.sv @@
// Testbench for the indexed insert/erase list: directed and random commands, scoreboarded.
`timescale 1ns / 1ps
module testbench;
  import ieel_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  logic [31:0] list_words[LIST_CAP];
  int        list_len = 0;
  int        gen_len = 0;
  int        gen_total = 0;
  logic [31:0] word_pool[8];
  int        errors = 0;
  int        cycles = 0;
  logic      took = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  indexed_insert_erase_list i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [2:0] list_insert(int at, logic [31:0] word);
    if (at > list_len) return ST_RANGE;
    if (list_len >= LIST_CAP) return ST_FULL;
    for (int k = list_len; k > at; k--) list_words[k] = list_words[k - 1];
    list_words[at] = word;
    list_len++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] list_erase(int at, output logic [31:0] gone);
    gone = '0;
    if (list_len == 0) return ST_EMPTY;
    if (at >= list_len) return ST_RANGE;
    gone = list_words[at];
    for (int k = at; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
    list_len--;
    return ST_OK;
  endfunction

  function automatic out_item_t apply_list_command(in_item_t t);
    out_item_t r;
    logic [31:0] gone;
    r = '0;
    gone = '0;
    r.status = ST_OK;
    case (t.command)
      CMD_INSERT:     r.status = list_insert(int'(t.position), t.item_word);
      CMD_PUSH_BACK:  r.status = list_insert(list_len, t.item_word);
      CMD_PUSH_FRONT: r.status = list_insert(0, t.item_word);
      CMD_ERASE:      r.status = list_erase(int'(t.position), gone);
      CMD_POP_BACK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.status = list_erase(list_len - 1, gone);
      end
      CMD_POP_FRONT:  r.status = list_erase(0, gone);
      CMD_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int k = 0; k < list_len; k++) begin
          if (list_words[k] == t.item_word) begin
            r.status = ST_OK;
            r.found_index = k[5:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.removed_word = gone;
    r.entry_count = list_len[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic queue_cmd(logic [2:0] c, int pos, logic [31:0] w);
    in_item_t t;
    t.command = c;
    t.position = pos[6:0];
    t.item_word = w;
    pending_cmds.push_back(t);
    gen_total++;
    // rough occupancy tracking to steer the random phases
    case (c)
      CMD_INSERT:     if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
      CMD_PUSH_BACK, CMD_PUSH_FRONT: if (gen_len < LIST_CAP) gen_len++;
      CMD_ERASE:      if (pos < gen_len) gen_len--;
      CMD_POP_BACK, CMD_POP_FRONT: if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic queue_random(int grow_pct);
    int roll;
    int pos;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) begin
      if ($urandom_range(0, 99) < 85) pos = $urandom_range(0, gen_len);
      else pos = $urandom_range(0, 127);
      case ($urandom_range(0, 2))
        0: queue_cmd(CMD_INSERT, pos, pick_word());
        1: queue_cmd(CMD_PUSH_BACK, $urandom_range(0, 127), pick_word());
        default: queue_cmd(CMD_PUSH_FRONT, $urandom_range(0, 127), pick_word());
      endcase
    end else if (roll < grow_pct + 10) begin
      if ($urandom_range(0, 19) == 0) queue_cmd(CMD_UNUSED, $urandom_range(0, 127), $urandom);
      else if ($urandom_range(0, 9) < 7)
        queue_cmd(CMD_FIND, $urandom_range(0, 127), word_pool[$urandom_range(0, 7)]);
      else queue_cmd(CMD_FIND, $urandom_range(0, 127), $urandom);
    end else begin
      if (gen_len > 0 && $urandom_range(0, 99) < 85) pos = $urandom_range(0, gen_len - 1);
      else pos = $urandom_range(0, 127);
      case ($urandom_range(0, 2))
        0: queue_cmd(CMD_ERASE, pos, $urandom);
        1: queue_cmd(CMD_POP_BACK, $urandom_range(0, 127), $urandom);
        default: queue_cmd(CMD_POP_FRONT, $urandom_range(0, 127), $urandom);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 20);
        in_item <= pending_cmds.pop_front();
        start <= 1'b1;
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_item), 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.removed_word !== want.removed_word)
          report_mismatch("removed_word", out_item.removed_word, want.removed_word);
        if (out_item.found_index !== want.found_index)
          report_mismatch("found_index", 32'(out_item.found_index), 32'(want.found_index));
        if (out_item.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_item.entry_count), 32'(want.entry_count));
      end
    end
    if (rst_n && start && !busy) expected_results.push_back(apply_list_command(in_item));
    took <= rst_n && start && !busy;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int mode;
    int n;
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 8; k++) word_pool[k] = $urandom;

    // empty list corners, out-of-range indices, unused command, then inserts, finds and erases
    queue_cmd(CMD_POP_BACK, 0, 32'h0);
    queue_cmd(CMD_POP_FRONT, 0, 32'h0);
    queue_cmd(CMD_ERASE, 0, 32'h0);
    queue_cmd(CMD_FIND, 0, 32'h0);
    queue_cmd(CMD_INSERT, 1, 32'h1111_1111);
    queue_cmd(CMD_INSERT, 127, 32'h2222_2222);
    queue_cmd(CMD_UNUSED, 127, 32'hFFFF_FFFF);
    queue_cmd(CMD_INSERT, 0, 32'h0000_0000);
    queue_cmd(CMD_PUSH_BACK, 64, 32'hFFFF_FFFF);
    queue_cmd(CMD_PUSH_FRONT, 0, 32'h8000_0001);
    queue_cmd(CMD_INSERT, 3, 32'h1234_5678);
    queue_cmd(CMD_INSERT, 1, 32'hA5A5_A5A5);
    queue_cmd(CMD_FIND, 0, 32'hFFFF_FFFF);
    queue_cmd(CMD_FIND, 0, 32'h0000_0000);
    queue_cmd(CMD_FIND, 0, 32'hDEAD_BEEF);
    queue_cmd(CMD_ERASE, 5, 32'h0);
    queue_cmd(CMD_ERASE, 127, 32'h0);
    queue_cmd(CMD_ERASE, 2, 32'h0);
    queue_cmd(CMD_POP_BACK, 0, 32'h0);
    queue_cmd(CMD_PUSH_BACK, 0, 32'h8000_0001);
    queue_cmd(CMD_FIND, 0, 32'h8000_0001);
    queue_cmd(CMD_POP_FRONT, 0, 32'h0);
    queue_cmd(CMD_ERASE, 0, 32'h0);

    // random phases: fill to capacity, drain to empty, or churn
    gen_total = 0;
    mode = 0;
    while (gen_total < RANDOM_ITEMS) begin
      case (mode)
        0: begin
          while (gen_len < LIST_CAP) queue_random(75);
          n = $urandom_range(2, 5);
          repeat (n) queue_random(100);
        end
        1: begin
          while (gen_len > 0) queue_random(15);
          n = $urandom_range(2, 5);
          repeat (n) queue_random(0);
        end
        default: begin
          n = $urandom_range(30, 80);
          repeat (n) queue_random(45);
        end
      endcase
      mode = $urandom_range(0, 2);
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
